// ----- design/mcbc_pkg.sv -----
// Package for the Magma CBC block cipher.
// Holds the S-box table, round helpers, register indexes and shared types.
// No dependencies.
`default_nettype none

package mcbc_pkg;

    localparam int unsigned ROUNDS     = 32;
    localparam int unsigned RND_W      = $clog2(ROUNDS);
    localparam int unsigned KEYS       = 8;
    localparam int unsigned KEY_IDX_W  = $clog2(KEYS);
    localparam int unsigned FWD_ENC    = 24;
    localparam int unsigned FWD_DEC    = 8;
    localparam int unsigned ROT        = 11;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IV     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd5;

    localparam logic [3:0] SBOX [8][16] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             load;
        logic             round;
        logic             finish;
        logic [RND_W-1:0] rnd;
    } t_cmd;

    function automatic logic [31:0] subst(input logic [31:0] x);
        logic [31:0] r;
        r = '0;
        for (int j = 0; j < 8; j++) begin
            r[31-4*j -: 4] = SBOX[j][x[31-4*j -: 4]];
        end
        return r;
    endfunction

    function automatic logic [KEY_IDX_W-1:0] key_index(
        input logic [RND_W-1:0] rnd,
        input logic             dec
    );
        logic [RND_W-1:0] fwd;
        fwd = dec ? RND_W'(FWD_DEC) : RND_W'(FWD_ENC);
        return (rnd < fwd) ? rnd[KEY_IDX_W-1:0] : ~rnd[KEY_IDX_W-1:0];
    endfunction

    function automatic logic [31:0] sel_key(
        input logic [32*KEYS-1:0]   keys,
        input logic [KEY_IDX_W-1:0] idx
    );
        return keys[32*KEYS-1 - 32*idx -: 32];
    endfunction

endpackage

`default_nettype wire

// ----- design/mcbc_ctrl.sv -----
// Controller for the Magma CBC block cipher: request handshake, round count,
// output register valid. Depends on mcbc_pkg.
`default_nettype none

module mcbc_ctrl
    import mcbc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    output logic o_valid,
    input  wire  i_stall,
    output t_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rnd       <= n_rnd;
            r_out_valid <= n_out_valid;
        end
    end

    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_rnd        = r_rnd;
        n_out_valid  = r_out_valid && i_stall;
        o_cmd        = '0;
        o_cmd.rnd    = r_rnd;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.round = 1'b1;
                n_rnd       = r_rnd + 1'b1;
                if (r_rnd == RND_W'(ROUNDS-1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_RUN) && (r_rnd == '0))
        else $error("load did not start round zero");

    a_last_round_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_rnd == RND_W'(ROUNDS-1)) |=> (r_state == S_DONE))
        else $error("run did not end after last round");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> slot_free)
        else $error("result overwrote a pending output");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.round, o_cmd.finish}))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ----- design/mcbc_dpath.sv -----
// Datapath for the Magma CBC block cipher: Feistel round unit, CBC chain
// and output register. Depends on mcbc_pkg.
`default_nettype none

module mcbc_dpath
    import mcbc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_cmd                i_cmd,
    input  wire  [32*KEYS-1:0]  i_keys,
    input  wire  [63:0]         i_iv,
    input  wire                 i_dec,
    input  wire  [63:0]         i_data_block,
    input  wire                 i_first_block,
    output logic [63:0]         o_result_block
);

    logic [31:0] r_hi, r_lo;
    logic [63:0] r_xor;
    logic [63:0] r_in;
    logic        r_dec;
    logic [63:0] r_chain;
    logic [63:0] r_result;

    logic [63:0] chain_sel;
    logic [63:0] start_blk;
    logic [31:0] rkey;
    logic [31:0] sub;
    logic [31:0] g;
    logic [63:0] res;

    assign chain_sel = i_first_block ? i_iv : r_chain;
    assign start_blk = i_dec ? i_data_block : (i_data_block ^ chain_sel);
    assign rkey      = sel_key(i_keys, key_index(i_cmd.rnd, r_dec));
    assign sub       = subst(r_lo + rkey);
    assign g         = {sub[31-ROT:0], sub[31:32-ROT]} ^ r_hi;
    assign res       = r_dec ? ({r_hi, r_lo} ^ r_xor) : {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.finish) begin
            r_chain <= r_dec ? r_in : res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hi  <= start_blk[63:32];
            r_lo  <= start_blk[31:0];
            r_xor <= chain_sel;
            r_in  <= i_data_block;
            r_dec <= i_dec;
        end else if (i_cmd.round) begin
            if (i_cmd.rnd == RND_W'(ROUNDS-1)) begin
                r_hi <= g;
            end else begin
                r_hi <= r_lo;
                r_lo <= g;
            end
        end
        if (i_cmd.finish) begin
            r_result <= res;
        end
    end

    assign o_result_block = r_result;

endmodule

`default_nettype wire

// ----- design/magma_cbc_block_cipher.sv -----
// Magma (64-bit GOST block cipher) in CBC mode, top level.
// Input channel: i_valid / o_stall with i_data_block and i_first_block; a
// request is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_result_block; a result is taken
// when o_valid is high and i_stall is low.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0..3 key parts, 4 IV, 5 decrypt mode); other indexes are ignored.
// Write configuration only while no request is in flight.
// Operation: once a request is taken, one iterative round unit runs 32
// Feistel rounds, one round per cycle, then the result and chain are
// registered when the output register is free. A new request can be taken
// in the cycle after that; no request is taken while a block is in flight.
// A request with i_first_block set restarts the chain from the IV.
// Reset clears the configuration, the chain and the output valid.
// When the receiver stalls, the result holds in the output register; one
// more request may be taken and run, and it then waits until the output
// register frees.
// Depends on mcbc_pkg, mcbc_ctrl and mcbc_dpath.
`default_nettype none

module magma_cbc_block_cipher
    import mcbc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [63:0]          i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire  [63:0]          i_data_block,
    input  wire                  i_first_block,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [63:0]          o_result_block
);

    logic [63:0] r_key0, r_key1, r_key2, r_key3;
    logic [63:0] r_iv;
    logic        r_decrypt;
    t_cmd        cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0    <= '0;
            r_key1    <= '0;
            r_key2    <= '0;
            r_key3    <= '0;
            r_iv      <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0:    r_key0    <= i_cfg_data;
                CFG_KEY1:    r_key1    <= i_cfg_data;
                CFG_KEY2:    r_key2    <= i_cfg_data;
                CFG_KEY3:    r_key3    <= i_cfg_data;
                CFG_IV:      r_iv      <= i_cfg_data;
                CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    mcbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    mcbc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_keys         ({r_key0, r_key1, r_key2, r_key3}),
        .i_iv           (r_iv),
        .i_dec          (r_decrypt),
        .i_data_block   (i_data_block),
        .i_first_block  (i_first_block),
        .o_result_block (o_result_block)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for magma_cbc_block_cipher (Magma cipher, CBC mode).
// Predicts every result block from a local Magma/CBC model and checks it in order.
// Depends on mcbc_pkg and the magma_cbc_block_cipher RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mcbc_pkg::*;

    localparam int CYCLE_LIMIT      = 800_000;
    localparam int TAIL_CYCLES      = 40;
    localparam int TARGET_ITEMS     = 1900;
    localparam int LAST_PHASE_ITEMS = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [3:0] SUBST_TABLE [8][16] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    typedef struct packed {
        logic [63:0] data;
        logic        first;
    } t_blk_req;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;
    logic                 blk_valid = 1'b0;
    logic                 blk_stall;
    logic [63:0]          blk_data = '0;
    logic                 blk_first = 1'b0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [63:0]          res_block;

    // model state and configuration
    logic [63:0] key_word [4] = '{default: '0};
    logic [63:0] iv_reg = '0;
    logic        decrypt = 1'b0;
    logic [63:0] chain = '0;

    t_blk_req    pending_blocks [$];
    logic [63:0] expected_blocks [$];
    int          reqs_left = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          req_taken = 1'b0;
    bit          no_idle = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          flow_left = 0;
    t_blk_req    drv_req;
    logic [63:0] want_block;
    logic [63:0] pred_block;

    magma_cbc_block_cipher u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (blk_valid),
        .o_stall        (blk_stall),
        .i_data_block   (blk_data),
        .i_first_block  (blk_first),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_result_block (res_block)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] sbox_layer(input logic [31:0] x);
        logic [31:0] r;
        r = '0;
        for (int n = 0; n < 8; n++) begin
            r[4*n +: 4] = SUBST_TABLE[7-n][x[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_key(input logic [2:0] k);
        logic [63:0] w;
        w = key_word[k[2:1]];
        return k[0] ? w[31:0] : w[63:32];
    endfunction

    function automatic logic [63:0] magma_rounds(input logic [63:0] blk, input logic dec);
        logic [31:0] a, b, t, g;
        logic [2:0]  k;
        int          fwd;
        a = blk[63:32];
        b = blk[31:0];
        fwd = dec ? 8 : 24;
        for (int i = 0; i < 32; i++) begin
            k = (i < fwd) ? 3'(i) : 3'(7 - (i % 8));
            t = sbox_layer(b + sub_key(k));
            g = {t[20:0], t[31:21]} ^ a;
            if (i != 31) begin
                a = b;
                b = g;
            end else begin
                a = g;
            end
        end
        return {a, b};
    endfunction

    function automatic logic [63:0] next_cipher_block(input logic [63:0] data,
                                                      input logic first);
        logic [63:0] res;
        if (first) chain = iv_reg;
        if (decrypt) begin
            res = magma_rounds(data, 1'b1) ^ chain;
            chain = data;
        end else begin
            res = magma_rounds(data ^ chain, 1'b0);
            chain = res;
        end
        return res;
    endfunction

    function automatic logic [63:0] random_block();
        int r;
        r = $urandom_range(0, 63);
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return 64'd1 << r;
            3: return ~(64'd1 << r);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        case (idx)
            CFG_KEY0:    key_word[0] = val;
            CFG_KEY1:    key_word[1] = val;
            CFG_KEY2:    key_word[2] = val;
            CFG_KEY3:    key_word[3] = val;
            CFG_IV:      iv_reg = val;
            CFG_DECRYPT: decrypt = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_block(input logic [63:0] data, input logic first);
        t_blk_req req;
        req.data = data;
        req.first = first;
        pending_blocks = {pending_blocks, req};
        reqs_left++;
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (reqs_left != 0 || expected_blocks.size() != 0);
    endtask

    task automatic random_config();
        int          kind;
        logic [63:0] v;
        kind = $urandom_range(0, 5);
        for (int p = 0; p < 4; p++) begin
            v = (kind == 0) ? 64'd0 : (kind == 1) ? '1 : {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) write_reg(CFG_IDX_W'(CFG_KEY0 + p), v);
        end
        if ($urandom_range(0, 3) != 0) write_reg(CFG_IV, random_block());
        if ($urandom_range(0, 3) != 0) write_reg(CFG_DECRYPT, {$urandom, $urandom});
        if ($urandom_range(0, 7) == 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
        end
    endtask

    task automatic queue_messages(input int n);
        int   j;
        int   len;
        logic f;
        j = 0;
        while (j < n) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int m = 0; m < len && j < n; m++) begin
                f = (m == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                queue_block(random_block(), f);
                j++;
            end
        end
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch (%s): expected %h got %h", what, want, got);
        end
    endtask

    // accept requests and predict their results
    always @(posedge clk) begin
        if (rst_n && blk_valid && !blk_stall) begin
            pred_block = next_cipher_block(blk_data, blk_first);
            expected_blocks = {expected_blocks, pred_block};
            reqs_left--;
            req_taken <= 1'b1;
        end else begin
            req_taken <= 1'b0;
        end
    end

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            blk_valid <= 1'b0;
        end else if (!blk_valid || req_taken) begin
            if (gap_left > 0) begin
                blk_valid <= 1'b0;
                gap_left--;
            end else if (pending_blocks.size() > 0) begin
                drv_req = pending_blocks.pop_front();
                blk_data <= drv_req.data;
                blk_first <= drv_req.first;
                blk_valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
            end else begin
                blk_valid <= 1'b0;
            end
        end
    end

    // result stall bursts
    always @(negedge clk) begin
        if (!rst_n || no_idle) begin
            res_stall <= 1'b0;
        end else if (stall_left > 0) begin
            res_stall <= 1'b1;
            stall_left--;
        end else if (flow_left > 0) begin
            res_stall <= 1'b0;
            flow_left--;
        end else begin
            res_stall <= 1'b0;
            stall_left = $urandom_range(0, 1) ? $urandom_range(1, 16) : 0;
            flow_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                    : $urandom_range(0, 40);
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (expected_blocks.size() == 0) begin
                note_mismatch("unexpected result", '0, res_block);
            end else begin
                want_block = expected_blocks.pop_front();
                if (res_block !== want_block) begin
                    note_mismatch("result_block", want_block, res_block);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int total;
        int n;
        total = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset configuration, chain zero before any first block
        queue_block(64'h0, 1'b0);
        queue_block('1, 1'b0);
        queue_block(64'h0123_4567_89ab_cdef, 1'b1);
        wait_drained();

        write_reg(CFG_KEY0, 64'hffee_ddcc_bbaa_9988);
        write_reg(CFG_KEY1, 64'h7766_5544_3322_1100);
        write_reg(CFG_KEY2, 64'hf0f1_f2f3_f4f5_f6f7);
        write_reg(CFG_KEY3, 64'hf8f9_fafb_fcfd_feff);
        write_reg(CFG_IV, 64'h0);
        write_reg(CFG_DECRYPT, 64'h0);
        queue_block(64'hfedc_ba98_7654_3210, 1'b1);
        queue_block(64'h0, 1'b0);
        queue_block('1, 1'b0);
        wait_drained();

        // decrypt, mode written with extra upper bits
        write_reg(CFG_IV, 64'h1234_5678_90ab_cdef);
        write_reg(CFG_DECRYPT, '1);
        queue_block(64'h4ee9_01e5_c2d8_ca3d, 1'b1);
        queue_block('1, 1'b0);
        queue_block(64'h0, 1'b0);
        wait_drained();

        // switch mode mid-message, keep chain
        write_reg(CFG_DECRYPT, 64'h2);
        queue_block(64'h5555_5555_5555_5555, 1'b0);
        queue_block(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        wait_drained();

        // writes past the register list are dropped
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, 64'h8000_0000_0000_0001);
        for (int p = 0; p < 4; p++) write_reg(CFG_IDX_W'(CFG_KEY0 + p), '1);
        queue_block(64'h0, 1'b1);
        queue_block('1, 1'b0);
        wait_drained();

        for (int p = 0; p < 4; p++) write_reg(CFG_IDX_W'(CFG_KEY0 + p), 64'h0);
        write_reg(CFG_IV, '1);
        write_reg(CFG_DECRYPT, 64'h1);
        queue_block(64'h0, 1'b1);
        queue_block('1, 1'b1);
        queue_block(64'h8000_0000_0000_0001, 1'b0);
        wait_drained();

        while (total < TARGET_ITEMS - LAST_PHASE_ITEMS) begin
            random_config();
            n = $urandom_range(60, 180);
            queue_messages(n);
            total += n;
            wait_drained();
        end

        no_idle = 1'b1;
        random_config();
        queue_messages(LAST_PHASE_ITEMS);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/mcbc_pkg.sv
design/mcbc_ctrl.sv
design/mcbc_dpath.sv
design/magma_cbc_block_cipher.sv
verif/testbench.sv
